FILE: design/double_to_decimal_mantissa_text_assert.svh
// assertion macros used by the formatter controller
`ifndef DOUBLE_TO_DECIMAL_MANTISSA_TEXT_ASSERT_SVH
`define DOUBLE_TO_DECIMAL_MANTISSA_TEXT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DTDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DTDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dtdm_pkg.sv
// shared constants, codes and control structs of the mantissa text formatter
package dtdm_pkg;

  localparam int FRACTION_DIGITS = 20;
  localparam int GEN_DIGITS      = FRACTION_DIGITS + 1;
  localparam int FRAC_BITS       = 52;
  localparam int EXP_W           = 11;
  localparam int IDX_W           = $clog2(GEN_DIGITS + 1);

  localparam logic [EXP_W-1:0] EXP_BIAS      = EXP_W'(1023);
  localparam logic [EXP_W-1:0] SUBNORMAL_MAG = EXP_W'(1022);

  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_STAR  = 7'h2A;
  localparam logic [6:0] CH_TWO   = 7'h32;
  localparam logic [6:0] CH_CARET = 7'h5E;
  localparam logic [6:0] CH_ZERO  = 7'h30;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [3:0] {
    CK_SIGN,
    CK_INT,
    CK_DOT,
    CK_FRAC,
    CK_STAR,
    CK_TWO,
    CK_CARET,
    CK_MINUS,
    CK_EXP
  } char_kind_e;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       gen;
    logic       round;
    logic       emit;
    logic       last;
    char_kind_e kind;
    idx_t       idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       gen_zero;
    logic       round_done;
    logic       out_free;
    idx_t       frac_len;
    logic       exp_neg;
    logic [1:0] exp_top;
  } sts_t;

endpackage

FILE: design/dtdm_if.sv
// valid/ready channel interfaces for the word input and the character output
interface dtdm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_bits;

  modport source (output valid, output raw_bits, input ready);
  modport sink   (input valid, input raw_bits, output ready);
endinterface

interface dtdm_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

FILE: design/dtdm_dp.sv
// datapath: fraction digit generator, rounding step, exponent digits, output register
module dtdm_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [63:0]      raw_bits_i,
  input  dtdm_pkg::cmd_t   cmd_i,
  output dtdm_pkg::sts_t   sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [6:0]       text_char_o,
  output logic             last_char_o
);

  // splits a magnitude below 1100 into thousands, hundreds, tens, units
  function automatic logic [3:0][3:0] exp_split(input logic [dtdm_pkg::EXP_W-1:0] m);
    logic [dtdm_pkg::EXP_W-1:0] r;
    logic [dtdm_pkg::EXP_W-1:0] s;
    logic [3:0]                 d;
    logic [3:0][3:0]            res;
    res = '0;
    r   = m;
    if (r >= dtdm_pkg::EXP_W'(1000)) begin
      res[3] = 4'd1;
      r      = r - dtdm_pkg::EXP_W'(1000);
    end
    d = '0;
    s = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= dtdm_pkg::EXP_W'(k * 100)) begin
        d = 4'(k);
        s = dtdm_pkg::EXP_W'(k * 100);
      end
    end
    res[2] = d;
    r      = r - s;
    d      = '0;
    s      = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= dtdm_pkg::EXP_W'(k * 10)) begin
        d = 4'(k);
        s = dtdm_pkg::EXP_W'(k * 10);
      end
    end
    res[1] = d;
    r      = r - s;
    res[0] = r[3:0];
    return res;
  endfunction

  logic                            sign_q;
  logic [1:0]                      int_q;
  logic [dtdm_pkg::FRAC_BITS-1:0]  rem_q;
  logic [3:0]                      digits_q [dtdm_pkg::GEN_DIGITS];
  dtdm_pkg::idx_t                  len_q;
  logic                            carry_q;
  logic                            neg_q;
  logic [dtdm_pkg::EXP_W-1:0]      mag_q;
  logic [3:0][3:0]                 edig_q;
  logic                            out_valid_q;
  logic [6:0]                      text_q;
  logic                            last_q;

  logic [dtdm_pkg::FRAC_BITS+3:0]  prod;
  logic [3:0]                      gen_digit;
  logic [3:0]                      rd_digit;
  logic [3:0]                      rnd_digit;
  logic                            rnd_carry;
  logic [dtdm_pkg::EXP_W-1:0]      efield;
  dtdm_pkg::idx_t                  idx_inc;
  logic [6:0]                      char_sel;

  assign efield    = raw_bits_i[62:52];
  assign prod      = ((dtdm_pkg::FRAC_BITS+4)'(rem_q) << 3) +
                     ((dtdm_pkg::FRAC_BITS+4)'(rem_q) << 1);
  assign gen_digit = prod[dtdm_pkg::FRAC_BITS+3:dtdm_pkg::FRAC_BITS];
  assign rd_digit  = digits_q[cmd_i.idx];
  assign rnd_carry = carry_q && (rd_digit == 4'd9);
  assign rnd_digit = !carry_q ? rd_digit : (rnd_carry ? 4'd0 : rd_digit + 4'd1);
  assign idx_inc   = cmd_i.idx + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sign_q <= raw_bits_i[63];
      int_q  <= {1'b0, efield != '0};
      rem_q  <= raw_bits_i[dtdm_pkg::FRAC_BITS-1:0];
      if (efield == '0) begin
        neg_q <= 1'b1;
        mag_q <= dtdm_pkg::SUBNORMAL_MAG;
      end else if (efield < dtdm_pkg::EXP_BIAS) begin
        neg_q <= 1'b1;
        mag_q <= dtdm_pkg::EXP_BIAS - efield;
      end else begin
        neg_q <= 1'b0;
        mag_q <= efield - dtdm_pkg::EXP_BIAS;
      end
    end
    if (cmd_i.gen) begin
      rem_q                <= prod[dtdm_pkg::FRAC_BITS-1:0];
      digits_q[cmd_i.idx]  <= gen_digit;
      if (cmd_i.idx == dtdm_pkg::idx_t'(dtdm_pkg::GEN_DIGITS - 1)) begin
        carry_q <= gen_digit >= 4'd5;
        len_q   <= '0;
      end else begin
        // the digit that empties the remainder is nonzero unless the fraction was zero
        len_q   <= (gen_digit != '0) ? idx_inc : '0;
      end
    end
    if (cmd_i.round) begin
      digits_q[cmd_i.idx] <= rnd_digit;
      carry_q             <= rnd_carry;
      if (len_q == '0 && rnd_digit != '0) begin
        len_q <= idx_inc;
      end
      if (cmd_i.idx == '0 && rnd_carry) begin
        int_q <= int_q + 2'd1;
      end
    end
    edig_q <= exp_split(mag_q);
  end

  always_comb begin
    case (cmd_i.kind)
      dtdm_pkg::CK_SIGN:  char_sel = sign_q ? dtdm_pkg::CH_MINUS : dtdm_pkg::CH_PLUS;
      dtdm_pkg::CK_INT:   char_sel = dtdm_pkg::CH_ZERO + 7'(int_q);
      dtdm_pkg::CK_DOT:   char_sel = dtdm_pkg::CH_DOT;
      dtdm_pkg::CK_FRAC:  char_sel = dtdm_pkg::CH_ZERO + 7'(rd_digit);
      dtdm_pkg::CK_STAR:  char_sel = dtdm_pkg::CH_STAR;
      dtdm_pkg::CK_TWO:   char_sel = dtdm_pkg::CH_TWO;
      dtdm_pkg::CK_CARET: char_sel = dtdm_pkg::CH_CARET;
      dtdm_pkg::CK_MINUS: char_sel = dtdm_pkg::CH_MINUS;
      dtdm_pkg::CK_EXP:   char_sel = dtdm_pkg::CH_ZERO + 7'(edig_q[cmd_i.idx[1:0]]);
      default:            char_sel = dtdm_pkg::CH_ZERO;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      text_q <= char_sel;
      last_q <= cmd_i.last;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.gen_zero   = prod[dtdm_pkg::FRAC_BITS-1:0] == '0;
    sts_o.round_done = (cmd_i.idx == '0) ||
                       (!rnd_carry && (len_q != '0 || rnd_digit != '0));
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.frac_len   = len_q;
    sts_o.exp_neg    = neg_q;
    if (mag_q >= dtdm_pkg::EXP_W'(1000)) begin
      sts_o.exp_top = 2'd3;
    end else if (mag_q >= dtdm_pkg::EXP_W'(100)) begin
      sts_o.exp_top = 2'd2;
    end else if (mag_q >= dtdm_pkg::EXP_W'(10)) begin
      sts_o.exp_top = 2'd1;
    end else begin
      sts_o.exp_top = 2'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = text_q;
  assign last_char_o = last_q;

endmodule

FILE: design/dtdm_ctrl.sv
// controller: sequences digit generation, rounding pass and character emission
`include "double_to_decimal_mantissa_text_assert.svh"

module dtdm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output dtdm_pkg::cmd_t cmd_o,
  input  dtdm_pkg::sts_t sts_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GEN   = 2'd1;
  localparam logic [1:0] S_ROUND = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]           state_q, state_d;
  dtdm_pkg::idx_t       idx_q, idx_d;
  dtdm_pkg::char_kind_e kind_q, kind_d;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;
    cmd_o.kind = kind_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = S_GEN;
        end
      end
      S_GEN: begin
        cmd_o.gen = 1'b1;
        if (idx_q == dtdm_pkg::idx_t'(dtdm_pkg::GEN_DIGITS - 1)) begin
          idx_d   = dtdm_pkg::idx_t'(dtdm_pkg::FRACTION_DIGITS - 1);
          state_d = S_ROUND;
        end else if (sts_i.gen_zero) begin
          kind_d  = dtdm_pkg::CK_SIGN;
          state_d = S_EMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_done) begin
          kind_d  = dtdm_pkg::CK_SIGN;
          state_d = S_EMIT;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          unique case (kind_q)
            dtdm_pkg::CK_SIGN: kind_d = dtdm_pkg::CK_INT;
            dtdm_pkg::CK_INT:
              kind_d = (sts_i.frac_len != '0) ? dtdm_pkg::CK_DOT : dtdm_pkg::CK_STAR;
            dtdm_pkg::CK_DOT: begin
              kind_d = dtdm_pkg::CK_FRAC;
              idx_d  = '0;
            end
            dtdm_pkg::CK_FRAC: begin
              if (dtdm_pkg::idx_t'(idx_q + 1'b1) == sts_i.frac_len) begin
                kind_d = dtdm_pkg::CK_STAR;
              end else begin
                idx_d = idx_q + 1'b1;
              end
            end
            dtdm_pkg::CK_STAR: kind_d = dtdm_pkg::CK_TWO;
            dtdm_pkg::CK_TWO:  kind_d = dtdm_pkg::CK_CARET;
            dtdm_pkg::CK_CARET: begin
              kind_d = sts_i.exp_neg ? dtdm_pkg::CK_MINUS : dtdm_pkg::CK_EXP;
              idx_d  = dtdm_pkg::idx_t'(sts_i.exp_top);
            end
            dtdm_pkg::CK_MINUS: begin
              kind_d = dtdm_pkg::CK_EXP;
              idx_d  = dtdm_pkg::idx_t'(sts_i.exp_top);
            end
            dtdm_pkg::CK_EXP: begin
              if (idx_q == '0) begin
                cmd_o.last = 1'b1;
                state_d    = S_IDLE;
              end else begin
                idx_d = idx_q - 1'b1;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      kind_q  <= dtdm_pkg::CK_SIGN;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      kind_q  <= kind_d;
    end
  end

  `DTDM_ASSERT_IMP(a_emit_needs_room, cmd_o.emit, sts_i.out_free, "character issued into a full output register")
  `DTDM_ASSERT_NXT(a_last_goes_idle, cmd_o.emit && cmd_o.last, state_q == S_IDLE, "controller not idle after last character")
  `DTDM_ASSERT_IMP(a_gen_in_range, state_q == S_GEN, idx_q <= dtdm_pkg::idx_t'(dtdm_pkg::GEN_DIGITS - 1), "digit step beyond the last digit")

endmodule

FILE: design/double_to_decimal_mantissa_text.sv
// top level of the binary64 to decimal mantissa text formatter
//
//   channel  dir  payload                      beat
//   in_i     in   raw_bits[63:0]               one binary64 word
//   out_o    out  text_char[6:0], last_char    one ascii character
//
// sequence: a number is accepted, then g digit steps (1..21, one
//   multiply-by-ten of the 52-bit remainder each), then r rounding steps
//   (0 when fewer than 21 digits exist, else 1..20, one digit each, walking
//   back until the carry dies and the last nonzero digit is found), then the
//   characters (6..31) pass the output register, one per cycle unless stalled
// reset: asynchronous, active low; clears the controller and the output valid
// stalls: a stalled sink holds the output register and the character sequencer;
//   the next word is taken as soon as the last character sits in the register
module double_to_decimal_mantissa_text (
  input logic        clk_i,
  input logic        rst_ni,
  dtdm_in_if.sink    in_i,
  dtdm_out_if.source out_o
);

  dtdm_pkg::cmd_t cmd;
  dtdm_pkg::sts_t sts;
  logic           in_ready;

  // controller decides what the datapath does in each cycle
  dtdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath holds the word, the digit store and the output beat
  dtdm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .raw_bits_i  (in_i.raw_bits),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .text_char_o (out_o.text_char),
    .last_char_o (out_o.last_char)
  );

  assign in_i.ready = in_ready;

endmodule
